// ----- hdl/csvtok_pkg.sv -----
// csvtok_pkg: token kinds, error codes and character constants for the csv tokenizer
// no dependencies; used by csv_stream_tokenizer
`default_nettype none

package csvtok_pkg;

	typedef enum logic [1:0] {
		TOK_DATA  = 2'd0,
		TOK_FIELD = 2'd1,
		TOK_ROW   = 2'd2,
		TOK_ERROR = 2'd3
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_QUOTE_UNQUOTED = 2'd0,
		ERR_AFTER_CLOSE    = 2'd1,
		ERR_UNTERMINATED   = 2'd2
	} err_code_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_END  = 1'b1
	} cmd_t;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int unsigned REPORT_BITS = 32;

endpackage

`default_nettype wire

// ----- hdl/csv_stream_tokenizer.sv -----
// csv_stream_tokenizer: streaming csv tokenizer, one byte or end command per transaction
// depends on csvtok_pkg (token kinds, error codes, character constants)
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------------
//  item    | item_valid / item_ready    | command, text_byte
//  token   | token_valid / token_ready  | token_kind, data_byte, error_code, error_position
//
// an accepted transaction lands in the input register (_s1); there the
// flag update and token decode run in one short combinational step and the
// token, if any, is written to the output register (_s2) as s1 moves on
// token_valid rises once the token has passed the input register and is in the
// output register; one item per cycle is sustained while the token side keeps up
// items that give no token leave s1 without waiting on the token side, so a
// stalled token only holds back the next item that has a token to give
// arst_n clears all tokenizer flags, the byte position and both valid bits
`default_nettype none

module csv_stream_tokenizer #(
	parameter int unsigned POSITION_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic        command,
	input  wire logic [7:0]  text_byte,

	output logic             token_valid,
	input  wire logic        token_ready,
	output logic [1:0]       token_kind,
	output logic [7:0]       data_byte,
	output logic [1:0]       error_code,
	output logic [31:0]      error_position
);

	localparam int unsigned RB = csvtok_pkg::REPORT_BITS;

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// output register
	logic                   valid_s2;
	csvtok_pkg::tok_kind_t  kind_s2;
	logic [7:0]             data_s2;
	csvtok_pkg::err_code_t  code_s2;
	logic [RB-1:0]          pos_s2;

	// tokenizer state
	logic                     in_quotes_q;
	logic                     quote_pending_q;
	logic                     quote_closed_q;
	logic                     field_has_data_q;
	logic                     row_has_fields_q;
	logic                     swallow_lf_q;
	logic                     failed_q;
	logic [POSITION_BITS-1:0] pos_q;

	// next state and token decode
	logic                     n_in_quotes;
	logic                     n_quote_pending;
	logic                     n_quote_closed;
	logic                     n_field_has_data;
	logic                     n_row_has_fields;
	logic                     n_swallow_lf;
	logic                     n_failed;
	logic [POSITION_BITS-1:0] n_pos;
	logic                     emit;
	csvtok_pkg::tok_kind_t    kind_d;
	logic [7:0]               data_d;
	csvtok_pkg::err_code_t    code_d;
	logic                     is_err;
	logic                     lf_eaten;
	logic                     outside;

	logic                     adv_s1;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [RB-1:0]            pos_rep;

	// saturating position increment; the same value serves the error position
	// of a byte (position after counting it) and of an unterminated quote
	assign pos_inc = (pos_q == {POSITION_BITS{1'b1}}) ? pos_q
		: pos_q + {{(POSITION_BITS-1){1'b0}}, 1'b1};

	// report position saturated to 32 bits
	generate
		if (POSITION_BITS > RB) begin : g_pos_wide
			assign pos_rep = (|pos_inc[POSITION_BITS-1:RB]) ? {RB{1'b1}} : pos_inc[RB-1:0];
		end else if (POSITION_BITS == RB) begin : g_pos_equal
			assign pos_rep = pos_inc;
		end else begin : g_pos_narrow
			assign pos_rep = {{(RB-POSITION_BITS){1'b0}}, pos_inc};
		end
	endgenerate

	// one step of the tokenizer for the item held in s1
	always_comb begin
		n_in_quotes      = in_quotes_q;
		n_quote_pending  = quote_pending_q;
		n_quote_closed   = quote_closed_q;
		n_field_has_data = field_has_data_q;
		n_row_has_fields = row_has_fields_q;
		n_swallow_lf     = swallow_lf_q;
		n_failed         = failed_q;
		n_pos            = pos_q;
		emit             = 1'b0;
		kind_d           = csvtok_pkg::TOK_DATA;
		data_d           = 8'd0;
		code_d           = csvtok_pkg::ERR_QUOTE_UNQUOTED;
		is_err           = 1'b0;
		lf_eaten         = 1'b0;
		outside          = 1'b0;

		if (cmd_s1 == csvtok_pkg::CMD_END) begin
			// end of text: flush the final row or report an open quote, then reset
			if (!failed_q) begin
				if (in_quotes_q && !quote_pending_q) begin
					emit   = 1'b1;
					is_err = 1'b1;
					kind_d = csvtok_pkg::TOK_ERROR;
					code_d = csvtok_pkg::ERR_UNTERMINATED;
				end else if (field_has_data_q || row_has_fields_q) begin
					emit   = 1'b1;
					kind_d = csvtok_pkg::TOK_ROW;
				end
			end
			n_in_quotes      = 1'b0;
			n_quote_pending  = 1'b0;
			n_quote_closed   = 1'b0;
			n_field_has_data = 1'b0;
			n_row_has_fields = 1'b0;
			n_swallow_lf     = 1'b0;
			n_failed         = 1'b0;
			n_pos            = '0;
		end else if (!failed_q) begin
			n_pos = pos_inc;

			// lf right after a row-ending cr
			if (swallow_lf_q) begin
				n_swallow_lf = 1'b0;
				lf_eaten     = (byte_s1 == csvtok_pkg::CH_LF);
			end

			if (!lf_eaten) begin
				if (quote_pending_q) begin
					n_quote_pending = 1'b0;
					if (byte_s1 == csvtok_pkg::CH_QUOTE) begin
						// doubled quote stands for one quote
						n_field_has_data = 1'b1;
						emit             = 1'b1;
						data_d           = csvtok_pkg::CH_QUOTE;
					end else begin
						n_in_quotes    = 1'b0;
						n_quote_closed = 1'b1;
						outside        = 1'b1;
					end
				end else if (in_quotes_q) begin
					if (byte_s1 == csvtok_pkg::CH_QUOTE) begin
						n_quote_pending = 1'b1;
					end else begin
						n_field_has_data = 1'b1;
						emit             = 1'b1;
						data_d           = byte_s1;
					end
				end else begin
					outside = 1'b1;
				end

				if (outside) begin
					case (byte_s1)
						csvtok_pkg::CH_QUOTE: begin
							if (n_field_has_data || n_quote_closed) begin
								emit     = 1'b1;
								is_err   = 1'b1;
								kind_d   = csvtok_pkg::TOK_ERROR;
								code_d   = csvtok_pkg::ERR_QUOTE_UNQUOTED;
								n_failed = 1'b1;
							end else begin
								n_in_quotes = 1'b1;
							end
						end
						csvtok_pkg::CH_COMMA: begin
							n_field_has_data = 1'b0;
							n_quote_closed   = 1'b0;
							n_row_has_fields = 1'b1;
							emit             = 1'b1;
							kind_d           = csvtok_pkg::TOK_FIELD;
						end
						csvtok_pkg::CH_LF, csvtok_pkg::CH_CR: begin
							n_swallow_lf     = (byte_s1 == csvtok_pkg::CH_CR);
							n_field_has_data = 1'b0;
							n_quote_closed   = 1'b0;
							n_row_has_fields = 1'b0;
							emit             = 1'b1;
							kind_d           = csvtok_pkg::TOK_ROW;
						end
						default: begin
							if (n_quote_closed) begin
								emit     = 1'b1;
								is_err   = 1'b1;
								kind_d   = csvtok_pkg::TOK_ERROR;
								code_d   = csvtok_pkg::ERR_AFTER_CLOSE;
								n_failed = 1'b1;
							end else begin
								n_field_has_data = 1'b1;
								emit             = 1'b1;
								data_d           = byte_s1;
							end
						end
					endcase
				end
			end
		end
	end

	// s1 moves on when it has no token to give or the output register frees up
	assign adv_s1     = valid_s1 && (!emit || !valid_s2 || token_ready);
	assign item_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1  <= command;
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q      <= 1'b0;
			quote_pending_q  <= 1'b0;
			quote_closed_q   <= 1'b0;
			field_has_data_q <= 1'b0;
			row_has_fields_q <= 1'b0;
			swallow_lf_q     <= 1'b0;
			failed_q         <= 1'b0;
			pos_q            <= '0;
		end else if (adv_s1) begin
			in_quotes_q      <= n_in_quotes;
			quote_pending_q  <= n_quote_pending;
			quote_closed_q   <= n_quote_closed;
			field_has_data_q <= n_field_has_data;
			row_has_fields_q <= n_row_has_fields;
			swallow_lf_q     <= n_swallow_lf;
			failed_q         <= n_failed;
			pos_q            <= n_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && emit) begin
			valid_s2 <= 1'b1;
		end else if (token_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			kind_s2 <= kind_d;
			data_s2 <= data_d;
			code_s2 <= is_err ? code_d : csvtok_pkg::ERR_QUOTE_UNQUOTED;
			pos_s2  <= is_err ? pos_rep : '0;
		end
	end

	assign token_valid    = valid_s2;
	assign token_kind     = kind_s2;
	assign data_byte      = data_s2;
	assign error_code     = code_s2;
	assign error_position = pos_s2;

	// a pending closing quote only exists inside a quoted field
	a_pending_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> in_quotes_q)
		else $error("quote pending outside quotes");

	// after a row-ending cr the field is fresh and unquoted
	a_swallow_clean: assert property (@(posedge clk) disable iff (!arst_n)
		swallow_lf_q |-> (!in_quotes_q && !quote_closed_q && !field_has_data_q))
		else $error("cr swallow with open field state");

	// end of text returns every flag and the position to reset
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd_s1 == csvtok_pkg::CMD_END) |=>
		(!in_quotes_q && !quote_pending_q && !quote_closed_q && !field_has_data_q &&
		 !row_has_fields_q && !swallow_lf_q && !failed_q && pos_q == '0))
		else $error("state not cleared after end of text");

	// tokens other than errors carry zero code and position
	a_non_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 != csvtok_pkg::TOK_ERROR) |->
		(error_code == 2'd0 && error_position == '0))
		else $error("non-error token with error fields set");

	// a failed tokenizer gives no token for a text byte
	a_failed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && failed_q && cmd_s1 == csvtok_pkg::CMD_BYTE) |-> !emit)
		else $error("token after error");

endmodule

`default_nettype wire
